/* design/spline_reference_cost_accumulator_assert.svh */
// Assertion macros for the spline reference cost accumulator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SPLINE_REFERENCE_COST_ACCUMULATOR_ASSERT_SVH
`define SPLINE_REFERENCE_COST_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRCA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spline cost accumulator check failed");

// Next-cycle implication, disabled during reset.
`define SRCA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spline cost accumulator check failed");

`endif

/* design/srca_pkg.sv */
// Shared types and constants of the spline reference cost accumulator.
// No dependencies; used by srca_mul, the top level and the testbench.
package srca_pkg;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2
    } shift_t;

    typedef struct packed {
        logic   start;
        shift_t sh;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_sts_t;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

endpackage

/* design/spline_reference_cost_accumulator.sv */
// Top level of the spline reference cost accumulator: knot search, power
// table, Gram and linear read-modify-write. Depends on srca_pkg, srca_mul.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | action knot_slot position reference
//          |                      | cost_weight segment row column
//  out     | out_valid / out_stall| read_value status
//  cfg     | APB psel/penable     | paddr pwdata prdata (knot_count, order)
//
// A clear sweeps the Gram memory, and the linear memory along with it,
//   over all (MAX_KNOTS-1) * MAX_COEFFS^2 entries (540 by default).
// An add request scans the knots, then runs products on the shared
//   multiplier: 2n-3 powers, one weight product, n
//   (slope 2(n-1)) linear products and n*n (slope (n-1)^2) Gram products.
// Reset runs the same clearing sweep before the first request is taken.
// in_stall is high while a request is in work; a finished result waits in
//   the output register, and the next request is taken meanwhile.
`include "spline_reference_cost_accumulator_assert.svh"

module spline_reference_cost_accumulator #(
    parameter int MAX_KNOTS  = 16,
    parameter int MAX_COEFFS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [3:0]         knot_slot,
    input  logic signed [31:0] position,
    input  logic signed [31:0] reference,
    input  logic [30:0]        cost_weight,
    input  logic [3:0]         segment,
    input  logic [2:0]         row,
    input  logic [2:0]         column,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] read_value,
    output logic [1:0]         status
);
    import srca_pkg::*;

    localparam int SEGS      = MAX_KNOTS - 1;
    localparam int BLK       = MAX_COEFFS * MAX_COEFFS;
    localparam int NPOW      = 2 * MAX_COEFFS - 1;
    localparam int GDEPTH    = SEGS * BLK;
    localparam int LDEPTH    = SEGS * MAX_COEFFS;
    localparam int GAW       = $clog2(GDEPTH);
    localparam int LAW       = $clog2(LDEPTH);
    localparam int KAW       = $clog2(MAX_KNOTS);
    localparam int KCW       = $clog2(MAX_KNOTS + 1);
    localparam int CW        = $clog2(MAX_COEFFS);
    localparam int PW        = $clog2(NPOW);
    localparam int ORD_RESET = (5 > MAX_COEFFS - 1) ? MAX_COEFFS - 1 : 5;

    localparam logic [2:0] ACT_LOAD    = 3'd0;
    localparam logic [2:0] ACT_VALUE   = 3'd1;
    localparam logic [2:0] ACT_SLOPE   = 3'd2;
    localparam logic [2:0] ACT_RD_GRAM = 3'd3;
    localparam logic [2:0] ACT_RD_LIN  = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic REG_KNOTS = 1'b0;
    localparam logic REG_ORDER = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_KLOAD, S_KISSUE, S_KCHECK,
        S_POW, S_POW_W, S_C0, S_C0_W,
        S_LIN, S_LIN_W, S_LIN2, S_LIN2_W, S_LIN_WB,
        S_GRAM, S_GRAM_W, S_GRAM_WB,
        S_RD_G, S_RD_GD, S_RD_L, S_RD_LD, S_DONE
    } state_t;

    // saturating add, overflow flag in the top bit
    function automatic logic [64:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return {1'b1, a[63] ? Q_MIN : Q_MAX};
        end
        return {1'b0, s};
    endfunction

    // configuration
    logic [KCW-1:0] kc_reg;
    logic [CW-1:0]  order_reg;
    logic [KCW-1:0] kc_clamp;
    logic [CW-1:0]  order_clamp;
    logic           cfg_wr;

    // control and payload
    state_t             state_reg;
    logic [GAW-1:0]     clr_cnt_reg;
    logic               clr_resp_reg;
    logic [KAW-1:0]     kaddr_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] ref_reg;
    logic [30:0]        w_reg;
    logic               slope_reg;
    logic               sat_reg;
    logic [KAW-1:0]     seg_reg;
    logic signed [32:0] rel_reg;
    logic signed [63:0] pw_reg [NPOW];
    logic [PW-1:0]      pk_reg;
    logic signed [63:0] c0_reg;
    logic signed [63:0] t_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      r_reg;
    logic [CW-1:0]      c_reg;
    logic signed [63:0] res_value_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    logic signed [63:0] read_value_reg;
    logic [1:0]         status_reg;

    // memories
    logic signed [31:0] knot_mem [MAX_KNOTS];
    logic signed [63:0] gram_mem [GDEPTH];
    logic signed [63:0] lin_mem  [LDEPTH];
    logic signed [31:0] krdata_reg;
    logic signed [63:0] g_rdata_reg;
    logic signed [63:0] l_rdata_reg;

    logic [GAW-1:0]     g_addr;
    logic [LAW-1:0]     l_addr;
    logic               g_we;
    logic               l_we;
    logic               k_we;
    logic [64:0]        g_sum;
    logic [64:0]        l_sum;
    logic signed [63:0] g_wdata;
    logic signed [63:0] l_wdata;

    // multiplier
    mul_ctl_t           mul_ctl;
    mul_sts_t           mul_sts;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic signed [63:0] product;

    logic [PW-1:0]        pw_idx;
    logic signed [63:0]   pw_rd;
    logic signed [32:0]   rel_now;
    logic [2*CW-1:0]      rc;
    logic [31+2*CW:0]     kprod;
    logic                 lskip;
    logic                 gskip;
    logic                 g_last;
    logic                 sat_fin;
    logic                 rd_seg_ok;

    srca_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .sts     (mul_sts),
        .product (product)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        if (pwdata[4:0] < 5'd2)
        begin
            kc_clamp = KCW'(2);
        end
        else if (32'(pwdata[4:0]) > MAX_KNOTS)
        begin
            kc_clamp = KCW'(MAX_KNOTS);
        end
        else
        begin
            kc_clamp = KCW'(pwdata[4:0]);
        end
        if (pwdata[2:0] == 3'd0)
        begin
            order_clamp = CW'(1);
        end
        else if (32'(pwdata[2:0]) > MAX_COEFFS - 1)
        begin
            order_clamp = CW'(MAX_COEFFS - 1);
        end
        else
        begin
            order_clamp = CW'(pwdata[2:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg    <= KCW'(2);
            order_reg <= CW'(ORD_RESET);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_KNOTS)
            begin
                kc_reg <= kc_clamp;
            end
            else
            begin
                order_reg <= order_clamp;
            end
        end
    end

    assign prdata = (paddr[2] == REG_ORDER) ? 32'(order_reg) : 32'(kc_reg);

    // ---------------- datapath helpers ----------------
    assign lskip   = slope_reg && (j_reg == '0);
    assign gskip   = slope_reg && (r_reg == '0 || c_reg == '0);
    assign g_last  = (r_reg == order_reg) && (c_reg == order_reg);
    assign rel_now = {pos_reg[31], pos_reg} - {prev_reg[31], prev_reg};
    assign rc      = r_reg * c_reg;
    assign kprod   = {w_reg, 1'b0} * rc;
    assign g_sum   = add_sat(g_rdata_reg, t_reg);
    assign l_sum   = add_sat(l_rdata_reg, t_reg);
    assign sat_fin = sat_reg || ((state_reg == S_GRAM_WB) && g_sum[64]);
    assign rd_seg_ok = 32'(segment) < 32'(kc_reg) - 1;

    always_comb
    begin
        unique case (state_reg)
            S_POW:   pw_idx = pk_reg - PW'(1);
            S_LIN:   pw_idx = slope_reg ? PW'(j_reg) - PW'(1) : PW'(j_reg);
            S_GRAM:  pw_idx = slope_reg ? PW'(r_reg) + PW'(c_reg) - PW'(2)
                                        : PW'(r_reg) + PW'(c_reg);
            default: pw_idx = '0;
        endcase
    end
    assign pw_rd = pw_reg[pw_idx];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_ctl = '{start: 1'b0, sh: SH_0};
        op_a    = '0;
        op_b    = '0;
        unique case (state_reg)
            S_POW:
            begin
                mul_ctl = '{start: 1'b1, sh: SH_16};
                op_a    = pw_rd;
                op_b    = {{31{rel_reg[32]}}, rel_reg};
            end
            S_C0:
            begin
                mul_ctl = '{start: 1'b1, sh: SH_0};
                op_a    = {{32{ref_reg[31]}}, ref_reg};
                op_b    = {33'd0, w_reg};
            end
            S_LIN:
            begin
                mul_ctl = '{start: !lskip, sh: SH_32};
                op_a    = c0_reg;
                op_b    = pw_rd;
            end
            S_LIN2:
            begin
                mul_ctl = '{start: 1'b1, sh: SH_0};
                op_a    = t_reg;
                op_b    = 64'(j_reg);
            end
            S_GRAM:
            begin
                // value points weigh every entry by 2w, slope points by 2w*r*c
                mul_ctl = '{start: !gskip, sh: SH_16};
                op_a    = pw_rd;
                op_b    = slope_reg ? 64'(kprod) : 64'({w_reg, 1'b0});
            end
            default:
            begin
                mul_ctl = '{start: 1'b0, sh: SH_0};
            end
        endcase
    end

    // ---------------- memories ----------------
    assign g_addr = (state_reg == S_CLEAR) ? clr_cnt_reg
                  : GAW'(32'(seg_reg) * BLK + 32'(r_reg) * MAX_COEFFS + 32'(c_reg));
    assign l_addr = (state_reg == S_CLEAR) ? LAW'(clr_cnt_reg)
                  : LAW'(32'(seg_reg) * MAX_COEFFS + 32'(j_reg));
    assign g_we    = (state_reg == S_CLEAR) || (state_reg == S_GRAM_WB);
    assign l_we    = ((state_reg == S_CLEAR) && (32'(clr_cnt_reg) < LDEPTH))
                  || (state_reg == S_LIN_WB);
    assign k_we    = (state_reg == S_KLOAD);
    assign g_wdata = (state_reg == S_CLEAR) ? 64'sd0 : g_sum[63:0];
    assign l_wdata = (state_reg == S_CLEAR) ? 64'sd0 : l_sum[63:0];

    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            knot_mem[kaddr_reg] <= pos_reg;
        end
        krdata_reg <= knot_mem[kaddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gram_mem[g_addr] <= g_wdata;
        end
        g_rdata_reg <= gram_mem[g_addr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lin_mem[l_addr] <= l_wdata;
        end
        l_rdata_reg <= lin_mem[l_addr];
    end

    // ---------------- sequencer ----------------
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the taken result; S_DONE reloads the register itself
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    // sweep both accumulators, one entry per cycle
                    if (clr_cnt_reg == GAW'(GDEPTH - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= clr_resp_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + GAW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pos_reg        <= position;
                        ref_reg        <= reference;
                        w_reg          <= cost_weight;
                        slope_reg      <= (action == ACT_SLOPE);
                        sat_reg        <= 1'b0;
                        res_value_reg  <= '0;
                        priority case (action)
                            ACT_LOAD:
                            begin
                                if (32'(knot_slot) < MAX_KNOTS)
                                begin
                                    kaddr_reg      <= KAW'(knot_slot);
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_KLOAD;
                                end
                                else
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_DONE;
                                end
                            end
                            ACT_VALUE, ACT_SLOPE:
                            begin
                                kaddr_reg      <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_KISSUE;
                            end
                            ACT_RD_GRAM:
                            begin
                                if (rd_seg_ok && (row <= 3'(order_reg))
                                        && (column <= 3'(order_reg)))
                                begin
                                    seg_reg        <= KAW'(segment);
                                    r_reg          <= CW'(row);
                                    c_reg          <= CW'(column);
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_RD_G;
                                end
                                else
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_DONE;
                                end
                            end
                            ACT_RD_LIN:
                            begin
                                if (rd_seg_ok && (row <= 3'(order_reg)))
                                begin
                                    seg_reg        <= KAW'(segment);
                                    j_reg          <= CW'(row);
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_RD_L;
                                end
                                else
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_DONE;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                clr_cnt_reg    <= '0;
                                clr_resp_reg   <= 1'b1;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_CLEAR;
                            end
                            default:
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_KLOAD:
                begin
                    state_reg <= S_DONE;
                end
                S_KISSUE:
                begin
                    state_reg <= S_KCHECK;
                end
                S_KCHECK:
                begin
                    // upper-bound scan; left knot trails one step behind
                    if (kaddr_reg == '0)
                    begin
                        prev_reg  <= krdata_reg;
                        kaddr_reg <= KAW'(1);
                        state_reg <= S_KISSUE;
                    end
                    else if ((krdata_reg > pos_reg)
                            || (KCW'(kaddr_reg) == kc_reg - KCW'(1)))
                    begin
                        seg_reg   <= kaddr_reg - KAW'(1);
                        rel_reg   <= rel_now;
                        pw_reg[0] <= 64'sh1_0000_0000;
                        pw_reg[1] <= {{15{rel_now[32]}}, rel_now, 16'd0};
                        pk_reg    <= PW'(2);
                        state_reg <= S_POW;
                    end
                    else
                    begin
                        prev_reg  <= krdata_reg;
                        kaddr_reg <= kaddr_reg + KAW'(1);
                        state_reg <= S_KISSUE;
                    end
                end
                S_POW:
                begin
                    state_reg <= S_POW_W;
                end
                S_POW_W:
                begin
                    if (mul_sts.done)
                    begin
                        pw_reg[pk_reg] <= product;
                        sat_reg        <= sat_reg | mul_sts.sat;
                        if (pk_reg == PW'({order_reg, 1'b0}))
                        begin
                            state_reg <= S_C0;
                        end
                        else
                        begin
                            pk_reg    <= pk_reg + PW'(1);
                            state_reg <= S_POW;
                        end
                    end
                end
                S_C0:
                begin
                    state_reg <= S_C0_W;
                end
                S_C0_W:
                begin
                    if (mul_sts.done)
                    begin
                        // c0 = -2*ref*w, exact
                        c0_reg    <= 64'sd0 - {product[62:0], 1'b0};
                        j_reg     <= '0;
                        state_reg <= S_LIN;
                    end
                end
                S_LIN:
                begin
                    if (lskip)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_LIN_W;
                    end
                end
                S_LIN_W:
                begin
                    if (mul_sts.done)
                    begin
                        t_reg     <= product;
                        sat_reg   <= sat_reg | mul_sts.sat;
                        state_reg <= slope_reg ? S_LIN2 : S_LIN_WB;
                    end
                end
                S_LIN2:
                begin
                    state_reg <= S_LIN2_W;
                end
                S_LIN2_W:
                begin
                    if (mul_sts.done)
                    begin
                        t_reg     <= product;
                        sat_reg   <= sat_reg | mul_sts.sat;
                        state_reg <= S_LIN_WB;
                    end
                end
                S_LIN_WB:
                begin
                    sat_reg <= sat_reg | l_sum[64];
                    if (j_reg == order_reg)
                    begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_GRAM;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_LIN;
                    end
                end
                S_GRAM_W:
                begin
                    if (mul_sts.done)
                    begin
                        t_reg     <= product;
                        sat_reg   <= sat_reg | mul_sts.sat;
                        state_reg <= S_GRAM_WB;
                    end
                end
                S_GRAM, S_GRAM_WB:
                begin
                    if (state_reg == S_GRAM && !gskip)
                    begin
                        state_reg <= S_GRAM_W;
                    end
                    else
                    begin
                        // advance to the next block entry
                        sat_reg <= sat_fin;
                        if (g_last)
                        begin
                            res_status_reg <= sat_fin ? ST_SAT : ST_OK;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            if (c_reg == order_reg)
                            begin
                                c_reg <= '0;
                                r_reg <= r_reg + CW'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + CW'(1);
                            end
                            state_reg <= S_GRAM;
                        end
                    end
                end
                S_RD_G:
                begin
                    state_reg <= S_RD_GD;
                end
                S_RD_GD:
                begin
                    res_value_reg <= g_rdata_reg;
                    state_reg     <= S_DONE;
                end
                S_RD_L:
                begin
                    state_reg <= S_RD_LD;
                end
                S_RD_LD:
                begin
                    res_value_reg <= l_rdata_reg;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        read_value_reg <= res_value_reg;
                        status_reg     <= res_status_reg;
                        clr_resp_reg   <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // ---------------- checks ----------------
    `SRCA_ASSERT_IMP(a_mul_done_in_wait, mul_sts.done, (state_reg == S_POW_W || state_reg == S_C0_W || state_reg == S_LIN_W || state_reg == S_LIN2_W || state_reg == S_GRAM_W))
    `SRCA_ASSERT_NXT(a_gram_wb_after_product, (state_reg == S_GRAM_W) && mul_sts.done, state_reg == S_GRAM_WB)
    `SRCA_ASSERT_IMP(a_wb_follows_wait, state_reg == S_GRAM_WB, $past(state_reg) == S_GRAM_W)
    `SRCA_ASSERT_IMP(a_fail_reads_zero, out_valid && (status != ST_OK), read_value == 64'sd0)

endmodule

/* design/srca_mul.sv */
// Shared 64x64 multiply with shift, truncation toward zero and saturation.
// Four 32x32 partial products over successive cycles; depends on srca_pkg.
module srca_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  srca_pkg::mul_ctl_t ctl,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output srca_pkg::mul_sts_t sts,
    output logic signed [63:0] product
);
    import srca_pkg::*;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         done_reg;
    logic         sat_reg;
    logic         neg_reg;
    shift_t       sh_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [63:0]  prod_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [127:0] pp_wide;
    logic [127:0] shifted;
    logic [63:0]  lim;
    logic         ovf;
    logic [63:0]  result;

    always_comb
    begin
        pa = (cnt_reg == 3'd2 || cnt_reg == 3'd3) ? ua_reg[63:32] : ua_reg[31:0];
        pb = (cnt_reg == 3'd1 || cnt_reg == 3'd3) ? ub_reg[63:32] : ub_reg[31:0];
        // align the partial product of the previous step
        if (cnt_reg == 3'd4)
        begin
            pp_wide = {pp_reg, 64'd0};
        end
        else if (cnt_reg == 3'd2 || cnt_reg == 3'd3)
        begin
            pp_wide = {32'd0, pp_reg, 32'd0};
        end
        else
        begin
            pp_wide = {64'd0, pp_reg};
        end
        unique case (sh_reg)
            SH_16:   shifted = acc_reg >> 16;
            SH_32:   shifted = acc_reg >> 32;
            default: shifted = acc_reg;
        endcase
        lim    = neg_reg ? Q_MIN : Q_MAX;
        ovf    = (|shifted[127:64]) || (shifted[63:0] > lim);
        result = ovf ? (neg_reg ? Q_MIN : Q_MAX)
                     : (neg_reg ? 64'd0 - shifted[63:0] : shifted[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            neg_reg <= op_a[63] ^ op_b[63];
            ua_reg  <= op_a[63] ? 64'd0 - op_a : op_a;
            ub_reg  <= op_b[63] ? 64'd0 - op_b : op_b;
            sh_reg  <= ctl.sh;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= 3'd3)
            begin
                pp_reg <= pa * pb;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_wide;
            end
            if (cnt_reg == 3'd5)
            begin
                prod_reg <= result;
                sat_reg  <= ovf;
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.sat  = sat_reg;
    assign product  = prod_reg;

endmodule

/* test/spline_reference_cost_accumulator_tb.sv */
// Self-checking testbench of the spline reference cost accumulator.
// Needs srca_pkg and the top level; drives requests, APB writes and checks results.
module spline_reference_cost_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srca_pkg::*;

    localparam int MAX_KNOTS  = 16;
    localparam int MAX_COEFFS = 6;
    localparam int SEGS       = MAX_KNOTS - 1;
    localparam int BLK        = MAX_COEFFS * MAX_COEFFS;
    localparam int IDLE_LIMIT = 6000;
    localparam int LONG_HOLD  = 1500;
    localparam int PHASE_REQS = 230;

    // request actions
    localparam logic [2:0] ACT_LOAD_KNOT   = 3'd0;
    localparam logic [2:0] ACT_ADD_VALUE   = 3'd1;
    localparam logic [2:0] ACT_ADD_SLOPE   = 3'd2;
    localparam logic [2:0] ACT_READ_GRAM   = 3'd3;
    localparam logic [2:0] ACT_READ_LINEAR = 3'd4;
    localparam logic [2:0] ACT_CLEAR       = 3'd5;
    localparam logic [2:0] ACT_BAD_6       = 3'd6;
    localparam logic [2:0] ACT_BAD_7       = 3'd7;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // register addresses
    localparam logic [2:0] REG_KNOT_COUNT = 3'd0;
    localparam logic [2:0] REG_POLY_ORDER = 3'd4;

    typedef struct {
        logic [2:0]         action;
        logic [3:0]         knot_slot;
        logic signed [31:0] position;
        logic signed [31:0] reference;
        logic [30:0]        cost_weight;
        logic [3:0]         segment;
        logic [2:0]         row;
        logic [2:0]         column;
        bit                 typed;      // expectation written in the table
        logic signed [63:0] typed_value;
        logic [1:0]         typed_status;
    } request_t;

    typedef struct {
        logic signed [63:0] value;
        logic [1:0]         status;
    } cost_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [3:0]         knot_slot;
    logic signed [31:0] position;
    logic signed [31:0] reference;
    logic [30:0]        cost_weight;
    logic [3:0]         segment;
    logic [2:0]         row;
    logic [2:0]         column;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] read_value;
    logic [1:0]         status;

    spline_reference_cost_accumulator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .knot_slot(knot_slot), .position(position),
        .reference(reference), .cost_weight(cost_weight),
        .segment(segment), .row(row), .column(column),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .status(status)
    );

    // Predictor state: mirrors the knot table, the accumulators and the registers.
    logic signed [63:0] knot_mirror [MAX_KNOTS];
    logic signed [63:0] gram_mirror [SEGS*BLK];
    logic signed [63:0] linear_mirror [SEGS*MAX_COEFFS];
    int unsigned        knots_in_use;
    int unsigned        order_in_use;

    cost_result_t pending_results [$];
    int  error_count;
    int  idle_cycles;
    bit  quiet;          // no idling on either side
    int  hold_requests;  // long receiver hold-offs asked by the sender
    int  hold_served;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // (a*b) >> sh, truncated toward zero, saturated to 64 bits.
    function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int sh, inout bit sat);
        logic [63:0]  ua, ub, lim;
        logic [127:0] prod;
        bit           neg;
        neg  = a[63] ^ b[63];
        ua   = a[63] ? (64'd0 - a) : a;
        ub   = b[63] ? (64'd0 - b) : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod >> sh;
        lim  = neg ? Q_MIN : Q_MAX;
        if (prod[127:64] != 0 || prod[63:0] > lim)
        begin
            sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? (64'd0 - prod[63:0]) : prod[63:0];
    endfunction

    function automatic logic signed [63:0] add_q(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                inout bit sat);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat = 1'b1;
            return a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    // Accumulate one value or slope sample into its segment.
    function automatic void accumulate_point(input request_t rq, input bit slope,
                                             inout bit sat);
        logic signed [63:0] pw [2*MAX_COEFFS-1];
        logic signed [63:0] pos, rel, c0, w, t, k;
        int unsigned        n, i, seg, r, c, a;
        n   = order_in_use + 1;
        pos = rq.position;
        w   = {33'd0, rq.cost_weight};
        i   = 1;
        while (i < knots_in_use && !(knot_mirror[i] > pos))
            i++;
        if (i > knots_in_use - 1)
            i = knots_in_use - 1;
        seg   = i - 1;
        rel   = pos - knot_mirror[seg];
        pw[0] = 64'sd1 <<< 32;
        for (i = 1; i + 1 < 2*n; i++)
            pw[i] = (i == 1) ? rel * 64'sd65536 : mul_q(pw[i-1], rel, 16, sat);
        c0 = -64'sd2 * $signed({{32{rq.reference[31]}}, rq.reference}) * w;
        for (i = 0; i < n; i++)
        begin
            if (slope && i == 0)
                continue;
            if (slope)
            begin
                t = mul_q(c0, pw[i-1], 32, sat);
                t = mul_q(t, i, 0, sat);
            end
            else
                t = mul_q(c0, pw[i], 32, sat);
            a = seg*MAX_COEFFS + i;
            linear_mirror[a] = add_q(linear_mirror[a], t, sat);
        end
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
            begin
                a = seg*BLK + r*MAX_COEFFS + c;
                if (slope)
                begin
                    if (r == 0 || c == 0)
                        continue;
                    k = 64'sd2 * w * (r*c);
                    t = mul_q(pw[r+c-2], k, 16, sat);
                end
                else
                    t = mul_q(pw[r+c], 64'sd2 * w, 16, sat);
                gram_mirror[a] = add_q(gram_mirror[a], t, sat);
            end
    endfunction

    function automatic cost_result_t predict_cost(input request_t rq);
        cost_result_t res;
        bit           sat;
        int unsigned  n;
        n   = order_in_use + 1;
        res = '{value: 64'sd0, status: ST_OK};
        sat = 1'b0;
        case (rq.action)
            ACT_LOAD_KNOT:
                knot_mirror[rq.knot_slot] = rq.position;
            ACT_ADD_VALUE, ACT_ADD_SLOPE:
            begin
                accumulate_point(rq, rq.action == ACT_ADD_SLOPE, sat);
                if (sat)
                    res.status = ST_SAT;
            end
            ACT_READ_GRAM:
                if (rq.segment < knots_in_use - 1 && rq.row < n && rq.column < n)
                    res.value = gram_mirror[rq.segment*BLK + rq.row*MAX_COEFFS + rq.column];
                else
                    res.status = ST_RANGE;
            ACT_READ_LINEAR:
                if (rq.segment < knots_in_use - 1 && rq.row < n)
                    res.value = linear_mirror[rq.segment*MAX_COEFFS + rq.row];
                else
                    res.status = ST_RANGE;
            ACT_CLEAR:
            begin
                foreach (gram_mirror[j])
                    gram_mirror[j] = 64'sd0;
                foreach (linear_mirror[j])
                    linear_mirror[j] = 64'sd0;
            end
            default:
                res.status = ST_RANGE;
        endcase
        return res;
    endfunction

    function automatic request_t mk(input logic [2:0] act, input logic [3:0] slot,
                                    input logic [31:0] pos, input logic [31:0] refv,
                                    input logic [30:0] w, input logic [3:0] seg,
                                    input logic [2:0] r, input logic [2:0] c,
                                    input bit typed = 1'b0,
                                    input logic [63:0] tv = 64'd0,
                                    input logic [1:0] ts = ST_OK);
        request_t rq;
        rq = '{act, slot, pos, refv, w, seg, r, c, typed, tv, ts};
        return rq;
    endfunction

    // Random request, mostly well-formed samples and reads inside the current shape.
    function automatic request_t random_request();
        request_t    rq;
        int unsigned pick, n;
        n  = order_in_use + 1;
        rq = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            rq.action = ACT_LOAD_KNOT;
        else if (pick < 34)
            rq.action = ACT_ADD_VALUE;
        else if (pick < 58)
            rq.action = ACT_ADD_SLOPE;
        else if (pick < 80)
            rq.action = ACT_READ_GRAM;
        else if (pick < 95)
            rq.action = ACT_READ_LINEAR;
        else if (pick < 96)
            rq.action = ACT_CLEAR;
        else if (pick < 98)
            rq.action = $urandom_range(0, 1) ? ACT_BAD_6 : ACT_BAD_7;
        // keep most samples near the knots and weights moderate
        if ($urandom_range(0, 9) != 0)
        begin
            rq.position = knot_mirror[$urandom_range(0, knots_in_use - 1)]
                        + $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0000_8000;
            rq.reference   = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            rq.cost_weight = $urandom_range(0, 32'h0002_0000);
        end
        if ($urandom_range(0, 7) != 0)
        begin
            rq.segment = $urandom_range(0, knots_in_use - 2);
            rq.row     = $urandom_range(0, n - 1);
            rq.column  = $urandom_range(0, n - 1);
        end
        return rq;
    endfunction

    // Offer one request; predict its result at the accepting edge.
    task automatic send_request(input request_t rq);
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= rq.action;
        knot_slot   <= rq.knot_slot;
        position    <= rq.position;
        reference   <= rq.reference;
        cost_weight <= rq.cost_weight;
        segment     <= rq.segment;
        row         <= rq.row;
        column      <= rq.column;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        begin
            cost_result_t res;
            res = predict_cost(rq);
            if (rq.typed)
                res = '{value: rq.typed_value, status: rq.typed_status};
            pending_results.push_back(res);
        end
        // random gap after the request
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8) - 1)
                @(negedge clk);
        end
    endtask

    task automatic drop_valid_and_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // mirror the clamping of the block
        if (addr == REG_KNOT_COUNT)
            knots_in_use = (data[4:0] < 2) ? 2 : (data[4:0] > MAX_KNOTS) ? MAX_KNOTS
                                                                        : data[4:0];
        else
            order_in_use = (data[2:0] < 1) ? 1 : (data[2:0] > MAX_COEFFS - 1)
                                                 ? MAX_COEFFS - 1 : data[2:0];
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request.
    initial
    begin
        int burst;
        int held;
        burst = 0;
        held  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (held > 0)
            begin
                held--;
                out_stall <= 1'b1;
            end
            else if (hold_served < hold_requests)
            begin
                hold_served++;
                held = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 8) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h status=%0d", $time,
                             read_value, status);
                    error_count++;
                end
                else
                begin
                    cost_result_t exp_res;
                    exp_res = pending_results.pop_front();
                    if (read_value !== exp_res.value)
                    begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 exp_res.value, read_value);
                        error_count++;
                    end
                    if (status !== exp_res.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_res.status, status);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        request_t directed [$];
        int       settings [7][2];
        logic signed [31:0] knot_pos;
        error_count   = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        knots_in_use  = 2;
        order_in_use  = 5;
        foreach (knot_mirror[j])
            knot_mirror[j] = 64'sd0;
        foreach (gram_mirror[j])
            gram_mirror[j] = 64'sd0;
        foreach (linear_mirror[j])
            linear_mirror[j] = 64'sd0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; action = '0; knot_slot = '0; position = '0; reference = '0;
        cost_weight = '0; segment = '0; row = '0; column = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty stores, bad addresses, bad actions, extremes, clear.
        directed = '{
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_READ_LINEAR, 0, 0, 0, 0, 0, 5, 0, 1, 0, ST_OK),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 1, 0, 0, 1, 0, ST_RANGE),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 15, 7, 7, 1, 0, ST_RANGE),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 0, 6, 0, 1, 0, ST_RANGE),
            mk(ACT_READ_LINEAR, 0, 0, 0, 0, 0, 6, 0, 1, 0, ST_RANGE),
            mk(ACT_BAD_6, 15, -1, -1, 31'h7FFF_FFFF, 15, 7, 7, 1, 0, ST_RANGE),
            mk(ACT_BAD_7, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_RANGE),
            mk(ACT_LOAD_KNOT, 0, 32'sh0000_0000, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_LOAD_KNOT, 1, 32'sh0001_0000, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_LOAD_KNOT, 15, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_ADD_VALUE, 0, 32'sh0000_8000, 32'sh0001_0000, 31'h1_0000, 0, 0, 0),
            mk(ACT_ADD_SLOPE, 0, 32'sh0000_4000, -32'sh0002_0000, 31'h8000, 0, 0, 0),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 0, 5, 5),
            mk(ACT_READ_LINEAR, 0, 0, 0, 0, 0, 3, 0),
            // far right of the last knot, largest weight: saturates
            mk(ACT_ADD_VALUE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0, 0, 0),
            // left of the first knot
            mk(ACT_ADD_SLOPE, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 0, 5, 4),
            mk(ACT_READ_LINEAR, 0, 0, 0, 0, 0, 0, 0),
            mk(ACT_ADD_VALUE, 0, 32'sh0000_1000, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_OK),
            mk(ACT_READ_GRAM, 0, 0, 0, 0, 0, 5, 5, 1, 0, ST_OK),
            mk(ACT_READ_LINEAR, 0, 0, 0, 0, 0, 5, 0, 1, 0, ST_OK)
        };
        foreach (directed[j])
            send_request(directed[j]);
        drop_valid_and_drain();

        // Register settings per phase; out-of-range values check the clamping.
        settings = '{'{16, 5}, '{2, 1}, '{5, 3}, '{31, 0}, '{0, 7}, '{9, 2}, '{16, 5}};
        foreach (settings[p])
        begin
            write_register(REG_KNOT_COUNT, settings[p][0]);
            write_register(REG_POLY_ORDER, settings[p][1]);
            quiet = (p == 6);
            // fill the whole knot table in ascending order, sometimes tightly spaced
            knot_pos = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            for (int s = 0; s < MAX_KNOTS; s++)
            begin
                send_request(mk(ACT_LOAD_KNOT, s, knot_pos, 0, 0, 0, 0, 0));
                knot_pos += $urandom_range(0, 3) == 0 ? $urandom_range(1, 16)
                                                      : $urandom_range(1, 32'h0004_0000);
            end
            if (p == 1)
            begin
                // long receiver hold-off while requests keep coming
                hold_requests++;
            end
            for (int j = 0; j < PHASE_REQS; j++)
            begin
                if (p == 2 && j == PHASE_REQS / 2)
                    drop_valid_and_drain();
                send_request(random_request());
            end
            drop_valid_and_drain();
        end

        begin
            int spare;
            spare = 0;
            while (pending_results.size() != 0 && spare < IDLE_LIMIT)
            begin
                @(posedge clk);
                spare++;
            end
        end
        repeat (20)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
